// ===== design/slpg_pkg.sv =====
// Constants and types for the softmax log-prob / entropy gradient core.
// Holds the exp factor table, the ln scaling constants and register indexes.
// No dependencies.
package slpg_pkg;

  typedef logic [11:0][31:0] exp_tab_t;

  // exp(-2^k/256) in Q0.32, each factor the rounded square of the previous
  function automatic exp_tab_t exp_tab_build();
    exp_tab_t    t;
    logic [63:0] b;
    b = 64'd4278222805;
    for (int k = 0; k < 12; k++) begin
      t[k] = b[31:0];
      b = (b * b + 64'h8000_0000) >> 32;
    end
    return t;
  endfunction

  localparam exp_tab_t    EXP_TAB        = exp_tab_build();
  localparam logic [15:0] LN2_Q16        = 16'd45426;
  localparam logic [20:0] LN_EPS_MAG_Q16 = 21'd1207218;

  localparam logic REG_ENTROPY_SCALE = 1'b0;

endpackage

// ===== design/softmax_logprob_entropy_gradient_core.sv =====
// Softmax policy-gradient row core with entropy regularization.
// Uses slpg_pkg (exp table, ln constants, register index).
//
// Usage:
//  - Input channel (in_valid/in_stall): one beat per class logit. The beat
//    with row_last set closes the row and carries chosen_action and
//    grad_logprob. Non-last beats are taken in one cycle each.
//  - Output channel (out_valid/out_stall): after the last beat, one beat per
//    class in class order, result_last on the final one. log_prob,
//    row_entropy and bad_action repeat on every beat of the row.
//  - APB port: register 0 (byte address 0) is entropy_scale, Q4.12. Write
//    only while the core is idle.
//  - Row computation: a closing beat starts passes over the row on one shared
//    34x34 multiplier plus a bit-serial divider: a sum pass over each class, a
//    probability pass over each class (33-step divide, 16-round ln, the ln
//    skipped when p is 0), a log-prob step once (skipped on a bad action) and
//    an emit pass over each class that also waits out output stalls.
//    in_stall stays high for the whole row computation.
//  - A stalled output beat holds in the output register; the sequencer
//    waits for it to drain before loading the next class. The final beat
//    may still be waiting when the next row begins.
//  - Reset (rst, synchronous) clears the row state, the output valid and
//    entropy_scale. Logit/prob memories are not cleared.
module softmax_logprob_entropy_gradient_core
  import slpg_pkg::*;
#(
  parameter int MAX_CLASSES = 32
) (
  input  logic               clk,
  input  logic               rst,
  // input beats
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] logit,
  input  logic        [5:0]  chosen_action,
  input  logic signed [15:0] grad_logprob,
  input  logic               row_last,
  // result beats
  output logic               out_valid,
  input  logic               out_stall,
  output logic        [5:0]  class_index,
  output logic signed [23:0] class_gradient,
  output logic signed [15:0] log_prob,
  output logic        [15:0] row_entropy,
  output logic               bad_action,
  output logic               result_last,
  // APB
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic        [2:0]  paddr,
  input  logic        [31:0] pwdata,
  output logic        [31:0] prdata,
  output logic               pready
);

  localparam int IDXW = $clog2(MAX_CLASSES);
  localparam int CNTW = $clog2(MAX_CLASSES + 1);

  typedef enum logic [4:0] {
    S_IDLE, S_RD, S_PLOAD, S_EXP_INIT, S_EXP_MUL, S_EXP_UPD, S_EXP_DONE,
    S_DIV, S_DIV_DONE, S_LN_INIT, S_LN_MUL, S_LN_UPD, S_LN_SCALE, S_LN_RND,
    S_LN_DONE, S_ENT_ADD, S_G1, S_G2, S_G3, S_OUT
  } state_t;

  typedef enum logic [1:0] {PH_SUM, PH_PROB, PH_LP, PH_GRAD} phase_t;

  state_t state;
  phase_t phase;

  // config
  logic [15:0] entropy_scale;

  // row state
  logic [CNTW-1:0]    row_count;
  logic signed [15:0] running_max;
  logic [23:0]        exp_sum;
  logic [23:0]        entropy_acc;
  logic [IDXW-1:0]    idx;
  logic [5:0]         act_reg;
  logic signed [15:0] grad_reg;
  logic               bad_reg;
  logic [15:0]        ent_out;
  logic signed [15:0] lp_reg;

  // memories
  logic [15:0] logit_mem [MAX_CLASSES];
  logic [15:0] prob_mem  [MAX_CLASSES];
  logic [15:0] logit_rd;
  logic [15:0] prob_rd;
  logic [IDXW-1:0] rd_addr;

  // shared multiplier
  logic signed [33:0] mul_a, mul_b;
  logic signed [67:0] prod;

  // exp unit
  logic [32:0] ex_acc;
  logic [11:0] ex_x;
  logic        ex_zero;
  logic [3:0]  step;

  // divider
  logic [32:0] div_num;
  logic [23:0] div_rem;
  logic [17:0] div_quot;
  logic [5:0]  div_cnt;

  // ln unit
  logic [31:0] ln_m;
  logic [3:0]  ln_n;
  logic [15:0] ln_frac;
  logic [20:0] ln_res;
  logic [15:0] p_val;

  // gradient
  logic [31:0]        sp;
  logic signed [33:0] gi;
  logic signed [23:0] grad_res;

  logic in_acc;
  assign in_acc   = in_valid && !in_stall;
  assign in_stall = (state != S_IDLE);

  logic last_cls;
  assign last_cls = (CNTW'(idx) + CNTW'(1)) == row_count;

  assign rd_addr = (phase == PH_LP) ? IDXW'(act_reg) : idx;

  // exp helpers
  logic signed [16:0] ex_diff;
  logic [65:0]        ex_tmp;
  logic [32:0]        ex_next;
  logic [16:0]        exp_e;
  logic [32:0]        ex_rnd;
  assign ex_diff = 17'(running_max) - 17'($signed(logit_rd));
  assign ex_tmp  = {1'b0, prod[64:0]} + 66'h8000_0000;
  assign ex_next = ex_tmp[64:32];
  assign ex_rnd  = ex_acc + 33'h8000;
  assign exp_e   = ex_zero ? 17'd0 : ex_rnd[32:16];

  // divider step
  logic [24:0] div_sh;
  logic        div_ge;
  assign div_sh = {div_rem, div_num[32]};
  assign div_ge = div_sh >= {1'b0, exp_sum};

  logic [15:0] p_val_div;
  assign p_val_div = (exp_sum == 24'd0) ? 16'd0 :
                     (div_quot > 18'd65535) ? 16'hFFFF : div_quot[15:0];

  // ln helpers
  logic [3:0]  lead;
  logic [31:0] ln_t;
  logic [20:0] ln_a;
  logic [37:0] ln_sc;
  always_comb begin
    lead = '0;
    for (int i = 0; i < 16; i++) begin
      if (p_val[i]) lead = 4'(i);
    end
  end
  assign ln_t  = prod[61:30];
  assign ln_a  = {5'd16 - 5'(ln_n), 16'd0} - 21'(ln_frac);
  assign ln_sc = prod[37:0] + 38'h8000;

  // entropy accumulate
  logic [37:0] ent_tmp;
  logic [23:0] ent_next;
  logic [24:0] ent_r;
  assign ent_tmp  = prod[37:0] + 38'h8000;
  assign ent_next = entropy_acc + ent_tmp[39-2:16];
  assign ent_r    = {1'b0, ent_next} + 25'd8;

  // log-prob rounding
  logic [21:0] lp_q;
  assign lp_q = ({1'b0, ln_res} + 22'd32) >> 6;

  // gradient operands
  logic signed [17:0] ind_p;
  logic signed [24:0] v_term;
  assign ind_p  = ((!bad_reg && 7'(idx) == 7'(act_reg)) ? 18'sd65536 : 18'sd0)
                  - 18'($signed({1'b0, p_val}));
  assign v_term = $signed({1'b0, entropy_acc}) - $signed({4'b0, ln_res});

  logic signed [59:0] g_sum;
  logic signed [59:0] g_mag;
  logic signed [27:0] g_rnd;
  logic signed [23:0] g_sat;
  always_comb begin
    g_sum = (60'(gi) <<< 20) + 60'(prod);
    if (g_sum >= 0) begin
      g_mag = (g_sum + 60'sh8000_0000) >>> 32;
      g_rnd = 28'(g_mag);
    end else begin
      g_mag = ((-g_sum) + 60'sh8000_0000) >>> 32;
      g_rnd = -28'(g_mag);
    end
    if (g_rnd > 28'sd8388607)       g_sat = 24'sh7FFFFF;
    else if (g_rnd < -28'sd8388608) g_sat = 24'sh800000;
    else                            g_sat = 24'(g_rnd);
  end

  // multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_EXP_MUL: begin
        mul_a = 34'(ex_acc);
        mul_b = 34'(EXP_TAB[step]);
      end
      S_LN_MUL: begin
        mul_a = 34'(ln_m);
        mul_b = 34'(ln_m);
      end
      S_LN_SCALE: begin
        mul_a = 34'(ln_a);
        mul_b = 34'(LN2_Q16);
      end
      S_LN_DONE: begin
        if (phase == PH_PROB) begin
          mul_a = 34'(p_val);
          mul_b = 34'(ln_res);
        end else begin
          mul_a = 34'(entropy_scale);
          mul_b = 34'(p_val);
        end
      end
      S_G1: begin
        mul_a = 34'(grad_reg);
        mul_b = 34'(ind_p);
      end
      S_G2: begin
        mul_a = 34'(sp);
        mul_b = 34'(v_term);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  // memories
  always_ff @(posedge clk) begin
    if (in_acc && row_count < CNTW'(MAX_CLASSES)) begin
      logit_mem[row_count[IDXW-1:0]] <= logit;
    end
    if (state == S_DIV_DONE) begin
      prob_mem[idx] <= p_val_div;
    end
    logit_rd <= logit_mem[rd_addr];
    prob_rd  <= prob_mem[rd_addr];
  end

  // APB
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_ENTROPY_SCALE) ? 32'(entropy_scale) : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      entropy_scale <= '0;
    end else if (psel && penable && pwrite && paddr[2] == REG_ENTROPY_SCALE) begin
      entropy_scale <= pwdata[15:0];
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      phase       <= PH_SUM;
      row_count   <= '0;
      running_max <= 16'sh8000;
      exp_sum     <= '0;
      entropy_acc <= '0;
      idx         <= '0;
      out_valid   <= 1'b0;
    end else begin
      // S_OUT handles its own valid update
      if (out_valid && !out_stall && state != S_OUT) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_acc) begin
            if (row_count < CNTW'(MAX_CLASSES)) begin
              row_count <= row_count + CNTW'(1);
              if (logit > running_max) running_max <= logit;
            end
            if (row_last) begin
              act_reg  <= chosen_action;
              grad_reg <= grad_logprob;
              phase    <= PH_SUM;
              idx      <= '0;
              exp_sum  <= '0;
              state    <= S_RD;
            end
          end
        end
        S_RD: begin
          state <= (phase == PH_SUM || phase == PH_PROB) ? S_EXP_INIT : S_PLOAD;
        end
        S_PLOAD: begin
          p_val <= prob_rd;
          state <= S_LN_INIT;
        end
        S_EXP_INIT: begin
          ex_x    <= ex_diff[11:0];
          ex_zero <= ex_diff[16:12] != 5'd0;
          ex_acc  <= 33'h1_0000_0000;
          step    <= '0;
          state   <= S_EXP_MUL;
        end
        S_EXP_MUL: state <= S_EXP_UPD;
        S_EXP_UPD: begin
          if (ex_x[step]) ex_acc <= ex_next;
          step  <= step + 4'd1;
          state <= (step == 4'd11) ? S_EXP_DONE : S_EXP_MUL;
        end
        S_EXP_DONE: begin
          if (phase == PH_SUM) begin
            exp_sum <= exp_sum + 24'(exp_e);
            if (last_cls) begin
              phase       <= PH_PROB;
              idx         <= '0;
              entropy_acc <= '0;
            end else begin
              idx <= idx + IDXW'(1);
            end
            state <= S_RD;
          end else begin
            div_num  <= {exp_e, 16'd0} + 33'(exp_sum >> 1);
            div_rem  <= '0;
            div_quot <= '0;
            div_cnt  <= '0;
            state    <= S_DIV;
          end
        end
        S_DIV: begin
          div_rem  <= div_ge ? 24'(div_sh - {1'b0, exp_sum}) : div_sh[23:0];
          div_quot <= {div_quot[16:0], div_ge};
          div_num  <= div_num << 1;
          div_cnt  <= div_cnt + 6'd1;
          if (div_cnt == 6'd32) state <= S_DIV_DONE;
        end
        S_DIV_DONE: begin
          p_val <= p_val_div;
          state <= S_LN_INIT;
        end
        S_LN_INIT: begin
          if (p_val == 16'd0) begin
            ln_res <= LN_EPS_MAG_Q16;
            state  <= S_LN_DONE;
          end else begin
            ln_n    <= lead;
            ln_m    <= 32'(p_val) << (5'd30 - 5'(lead));
            ln_frac <= '0;
            step    <= '0;
            state   <= S_LN_MUL;
          end
        end
        S_LN_MUL: state <= S_LN_UPD;
        S_LN_UPD: begin
          if (ln_t[31]) begin
            ln_frac[4'd15 - step] <= 1'b1;
            ln_m <= ln_t >> 1;
          end else begin
            ln_m <= ln_t;
          end
          step  <= step + 4'd1;
          state <= (step == 4'd15) ? S_LN_SCALE : S_LN_MUL;
        end
        S_LN_SCALE: state <= S_LN_RND;
        S_LN_RND: begin
          ln_res <= ln_sc[36:16];
          state  <= S_LN_DONE;
        end
        S_LN_DONE: begin
          case (phase)
            PH_PROB: state <= S_ENT_ADD;
            PH_LP: begin
              lp_reg <= (lp_q >= 22'd32768) ? 16'sh8000 : -$signed(16'(lp_q));
              phase  <= PH_GRAD;
              idx    <= '0;
              state  <= S_RD;
            end
            default: state <= S_G1;
          endcase
        end
        S_ENT_ADD: begin
          entropy_acc <= ent_next;
          if (last_cls) begin
            ent_out <= (ent_r[24:4] > 21'd65535) ? 16'hFFFF : ent_r[19:4];
            bad_reg <= 7'(act_reg) >= 7'(row_count);
            if (7'(act_reg) >= 7'(row_count)) begin
              lp_reg <= '0;
              phase  <= PH_GRAD;
              idx    <= '0;
            end else begin
              phase <= PH_LP;
            end
          end else begin
            idx <= idx + IDXW'(1);
          end
          state <= S_RD;
        end
        S_G1: begin
          sp    <= prod[31:0];
          state <= S_G2;
        end
        S_G2: begin
          gi    <= prod[33:0];
          state <= S_G3;
        end
        S_G3: state <= S_OUT;
        S_OUT: begin
          if (!out_valid || !out_stall) begin
            out_valid      <= 1'b1;
            class_index    <= 6'(idx);
            class_gradient <= grad_res;
            log_prob       <= lp_reg;
            row_entropy    <= ent_out;
            bad_action     <= bad_reg;
            result_last    <= last_cls;
            if (last_cls) begin
              row_count   <= '0;
              running_max <= 16'sh8000;
              exp_sum     <= '0;
              entropy_acc <= '0;
              phase       <= PH_SUM;
              state       <= S_IDLE;
            end else begin
              idx   <= idx + IDXW'(1);
              state <= S_RD;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // gradient result, sampled after the last product lands
  always_ff @(posedge clk) begin
    if (state == S_G3) grad_res <= g_sat;
  end

endmodule
